// ===== hdl/rpn_stack_calculator_unit_macros.svh =====
// Assertion macros for the RPN stack calculator unit.
// Included by the top level; depends on nothing else.
`ifndef RPN_STACK_CALCULATOR_UNIT_MACROS_SVH
`define RPN_STACK_CALCULATOR_UNIT_MACROS_SVH
`define RPN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define RPN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== hdl/rpn_pkg.sv =====
// Package for the RPN stack calculator: modes, sequencer states, divider control types and constants.
// Used by every module of the block.
`default_nettype none
package rpn_pkg;
  localparam int STACK_DEPTH = 128;
  localparam int SP_W = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);
  localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

  typedef enum logic [2:0] {
    MODE_PUSH  = 3'd0,
    MODE_ADD   = 3'd1,
    MODE_SUB   = 3'd2,
    MODE_MUL   = 3'd3,
    MODE_DIV   = 3'd4,
    MODE_MOD   = 3'd5,
    MODE_PRINT = 3'd6,
    MODE_UNK   = 3'd7
  } mode_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_POP1, ST_WAIT1, ST_POP2, ST_WAIT2, ST_EXEC, ST_DIVRUN, ST_FINISH, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic is_mod;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;
endpackage
`default_nettype wire

// ===== hdl/rpn_stack_calculator_unit.sv =====
// Top level of the RPN stack calculator: sequencer, operand registers, shared divider.
// Depends on rpn_pkg, rpn_stack_mem, rpn_divider and the assertion macro header.
// Push and unknown commands go straight to the result; the others first pop their operands,
// and divide and modulo then wait on the shared divider; an empty pop skips its read wait.
// One request at a time; in_stall is high until the result is taken.
// Synchronous active-low reset empties the stack; stored values are not cleared.
`default_nettype none
`include "rpn_stack_calculator_unit_macros.svh"
module rpn_stack_calculator_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [2:0]  in_mode,
  input  wire logic signed [31:0] in_operand_value,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_printed,
  output logic signed [31:0] out_printed_value,
  output logic [1:0]       out_empty_pops,
  output logic             out_stack_full,
  output logic             out_zero_divisor,
  output logic             out_unknown_command,
  output logic             out_saturated,
  output logic [7:0]       out_depth_now
);
  import rpn_pkg::*;

  state_t state_r, state_nxt;
  mode_t  mode_r;
  logic [SP_W-1:0] sp_r, sp_nxt;
  logic signed [31:0] a_r, a_nxt, b_r, b_nxt, res_r, res_nxt;
  logic [1:0] under_r, under_nxt;
  logic full_r, full_nxt, zdiv_r, zdiv_nxt, sat_r, sat_nxt, push_r, push_nxt;
  logic sign_r, sign_nxt;
  logic signed [63:0] prod_r;
  logic we;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [31:0] wdata, rdata;
  div_ctl_t dctl;
  div_sts_t dsts;
  logic [63:0] dvd_mag, quo;
  logic [31:0] dvs_mag, rem;
  logic signed [32:0] sum;
  logic signed [47:0] shp;
  logic signed [31:0] ia, ib;
  logic [64:0] sq;

  rpn_stack_mem u_mem (.clk, .we, .waddr, .wdata, .raddr, .rdata);
  rpn_divider u_div (.clk, .rst_n, .ctl(dctl), .dividend_mag(dvd_mag),
    .divisor_mag(dvs_mag), .sts(dsts), .quotient(quo), .remainder(rem));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sp_r <= '0;
    end else begin
      state_r <= state_nxt;
      sp_r <= sp_nxt;
    end
    if (state_r == ST_IDLE && in_valid) begin
      mode_r <= mode_t'(in_mode);
    end
    a_r <= a_nxt;
    b_r <= b_nxt;
    res_r <= res_nxt;
    under_r <= under_nxt;
    full_r <= full_nxt;
    zdiv_r <= zdiv_nxt;
    sat_r <= sat_nxt;
    push_r <= push_nxt;
    sign_r <= sign_nxt;
    prod_r <= a_r * b_r;
  end

  always_comb begin
    ia = a_r[31] ? -((-a_r) >> 16) : (a_r >>> 16);
    ib = b_r[31] ? -((-b_r) >> 16) : (b_r >>> 16);
  end

  always_comb begin
    state_nxt = state_r;
    sp_nxt = sp_r;
    a_nxt = a_r;
    b_nxt = b_r;
    res_nxt = res_r;
    under_nxt = under_r;
    full_nxt = full_r;
    zdiv_nxt = zdiv_r;
    sat_nxt = sat_r;
    push_nxt = push_r;
    sign_nxt = sign_r;
    we = 1'b0;
    waddr = sp_r[ADDR_W-1:0];
    wdata = res_r;
    raddr = ADDR_W'(sp_r - SP_W'(1));
    dctl = '0;
    dvd_mag = '0;
    dvs_mag = '0;
    sum = '0;
    shp = '0;
    sq = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          under_nxt = '0;
          full_nxt = 1'b0;
          zdiv_nxt = 1'b0;
          sat_nxt = 1'b0;
          push_nxt = 1'b0;
          a_nxt = '0;
          b_nxt = '0;
          res_nxt = in_operand_value;
          if (mode_t'(in_mode) == MODE_PUSH) begin
            push_nxt = 1'b1;
            state_nxt = ST_FINISH;
          end else if (mode_t'(in_mode) == MODE_UNK) state_nxt = ST_FINISH;
          else state_nxt = ST_POP1;
        end
      end
      ST_POP1: begin
        if (sp_r == '0) begin
          under_nxt = under_r + 2'd1;
          b_nxt = '0;
          state_nxt = ST_POP2;
        end else begin
          sp_nxt = sp_r - SP_W'(1);
          state_nxt = ST_WAIT1;
        end
      end
      ST_WAIT1: begin
        b_nxt = rdata;
        state_nxt = ST_POP2;
      end
      ST_POP2: begin
        if (mode_r == MODE_PRINT) begin
          res_nxt = b_r;
          state_nxt = ST_FINISH;
        end else if ((mode_r == MODE_DIV && b_r == '0) ||
                     (mode_r == MODE_MOD && ib == '0)) begin
          zdiv_nxt = 1'b1;
          state_nxt = ST_FINISH;
        end else if (sp_r == '0) begin
          under_nxt = under_r + 2'd1;
          a_nxt = '0;
          state_nxt = ST_EXEC;
        end else begin
          sp_nxt = sp_r - SP_W'(1);
          state_nxt = ST_WAIT2;
        end
      end
      ST_WAIT2: begin
        a_nxt = rdata;
        state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        push_nxt = 1'b1;
        state_nxt = ST_FINISH;
        unique case (mode_r) inside
          MODE_ADD, MODE_SUB: begin
            sum = (mode_r == MODE_ADD) ? ({a_r[31], a_r} + {b_r[31], b_r})
                                       : ({a_r[31], a_r} - {b_r[31], b_r});
            if (sum > 33'sd2147483647) begin
              res_nxt = Q_MAX;
              sat_nxt = 1'b1;
            end else if (sum < -33'sd2147483648) begin
              res_nxt = Q_MIN;
              sat_nxt = 1'b1;
            end else res_nxt = sum[31:0];
          end
          MODE_MUL: begin
            push_nxt = 1'b0;
            state_nxt = ST_DIVRUN;
            sign_nxt = 1'b1;
          end
          MODE_DIV: begin
            push_nxt = 1'b0;
            sign_nxt = a_r[31] ^ b_r[31];
            dctl.start = 1'b1;
            dvd_mag = {16'd0, (a_r[31] ? 32'(-a_r) : 32'(a_r)), 16'd0};
            dvs_mag = b_r[31] ? 32'(-b_r) : 32'(b_r);
            state_nxt = ST_DIVRUN;
          end
          MODE_MOD: begin
            push_nxt = 1'b0;
            sign_nxt = ia[31];
            dctl.start = 1'b1;
            dctl.is_mod = 1'b1;
            dvd_mag = {32'd0, (ia[31] ? 32'(-ia) : 32'(ia))};
            dvs_mag = ib[31] ? 32'(-ib) : 32'(ib);
            state_nxt = ST_DIVRUN;
          end
          default: ;
        endcase
      end
      ST_DIVRUN: begin
        if (mode_r == MODE_MUL) begin
          shp = prod_r[63:16];
          push_nxt = 1'b1;
          state_nxt = ST_FINISH;
          if (shp > 48'sh0000_7FFF_FFFF) begin
            res_nxt = Q_MAX;
            sat_nxt = 1'b1;
          end else if (shp < -48'sh0000_8000_0000) begin
            res_nxt = Q_MIN;
            sat_nxt = 1'b1;
          end else res_nxt = shp[31:0];
        end else if (dsts.done) begin
          push_nxt = 1'b1;
          state_nxt = ST_FINISH;
          if (mode_r == MODE_MOD) begin
            res_nxt = sign_r ? -{rem[15:0], 16'd0} : {rem[15:0], 16'd0};
          end else begin
            sq = sign_r ? -{1'b0, quo} : {1'b0, quo};
            if (!sign_r && quo > 64'h7FFF_FFFF) begin
              res_nxt = Q_MAX;
              sat_nxt = 1'b1;
            end else if (sign_r && quo > 64'h8000_0000) begin
              res_nxt = Q_MIN;
              sat_nxt = 1'b1;
            end else res_nxt = sq[31:0];
          end
        end
      end
      ST_FINISH: begin
        if (push_r) begin
          if (sp_r < SP_W'(STACK_DEPTH)) begin
            we = 1'b1;
            sp_nxt = sp_r + SP_W'(1);
          end else full_nxt = 1'b1;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign in_stall = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_printed = (mode_r == MODE_PRINT);
  assign out_printed_value = (mode_r == MODE_PRINT) ? res_r : '0;
  assign out_empty_pops = under_r;
  assign out_stack_full = full_r;
  assign out_zero_divisor = zdiv_r;
  assign out_unknown_command = (mode_r == MODE_UNK);
  assign out_saturated = sat_r;
  assign out_depth_now = 8'(sp_r);

  `RPN_ASSERT_IMPL(a_sp_bound, 1'b1, sp_r <= SP_W'(STACK_DEPTH), "stack pointer overflow")
  `RPN_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "result dropped")
  `RPN_ASSERT_IMPL(a_busy_div, dsts.busy, state_r == ST_DIVRUN, "divider busy out of state")
endmodule
`default_nettype wire

// ===== hdl/rpn_divider.sv =====
// Iterative restoring divider, one quotient bit per cycle, 64-bit dividend.
// Depends on rpn_pkg.
`default_nettype none
module rpn_divider (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rpn_pkg::div_ctl_t ctl,
  input  wire logic [63:0]       dividend_mag,
  input  wire logic [31:0]       divisor_mag,
  output rpn_pkg::div_sts_t      sts,
  output logic [63:0]            quotient,
  output logic [31:0]            remainder
);
  import rpn_pkg::*;

  logic [63:0] q_r, q_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] d_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] shifted, diff;

  always_comb begin
    shifted = {rem_r[31:0], q_r[63]};
    diff = shifted - {1'b0, d_r};
    q_nxt = q_r;
    rem_nxt = rem_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      q_nxt = dividend_mag;
      rem_nxt = '0;
      cnt_nxt = ctl.is_mod ? 7'd32 : 7'd64;
      busy_nxt = 1'b1;
      if (ctl.is_mod) q_nxt = {dividend_mag[31:0], 32'd0};
    end else if (busy_r) begin
      if (!diff[32]) begin
        rem_nxt = diff;
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    if (ctl.start) d_r <= divisor_mag;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = q_r;
  assign remainder = rem_r[31:0];
endmodule
`default_nettype wire

// ===== hdl/rpn_stack_mem.sv =====
// Value stack storage: one write port, one registered read port.
// Depends on rpn_pkg.
`default_nettype none
module rpn_stack_mem (
  input  wire logic                       clk,
  input  wire logic                       we,
  input  wire logic [rpn_pkg::ADDR_W-1:0] waddr,
  input  wire logic [31:0]                wdata,
  input  wire logic [rpn_pkg::ADDR_W-1:0] raddr,
  output logic [31:0]                     rdata
);
  import rpn_pkg::*;

  logic [31:0] mem [STACK_DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire
